[design/cpga_pkg.sv]
// ----------------------------------------------------------------------------
// cpga_pkg
// Shared widths, register codes, pipeline control type and the 48-bit
// saturation helper for the cross-potential gradient accumulator.
// ----------------------------------------------------------------------------
package cpga_pkg;

  localparam int IDX_W       = 8;
  localparam int IN_W        = 32;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 2 * IN_W;
  localparam int DIFF_SHIFT  = 14;
  localparam int DIFF_W      = PROD_W + 1 - DIFF_SHIFT;
  localparam int NSIN_W      = DIFF_W + 1;
  localparam int SLOPE_SHIFT = 16;
  localparam int DIR_SHIFT   = 30;
  localparam int SAT_W       = NSIN_W + IN_W - SLOPE_SHIFT;
  localparam int GRAD_LANES  = 3;
  localparam int ACC_LANES   = GRAD_LANES + 1;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_X = 2'd0,
    CFG_DIR_Y = 2'd1,
    CFG_DIR_Z = 2'd2
  } cfg_reg_e;

  // Control that travels with each request through the pipeline.
  typedef struct packed {
    logic             first;
    logic [IDX_W-1:0] idx;
    logic             sat;
  } item_ctl_t;

  typedef struct packed {
    logic                    sat;
    logic signed [ACC_W-1:0] val;
  } sat_res_t;

  // Clip a wide signed value to the 48-bit accumulator range.
  function automatic sat_res_t sat_acc(logic signed [SAT_W-1:0] v);
    sat_res_t r;
    logic     all_one;
    logic     all_zero;
    all_one  = &v[SAT_W-1:ACC_W-1];
    all_zero = ~|v[SAT_W-1:ACC_W-1];
    if (all_one || all_zero) begin
      r.sat = 1'b0;
      r.val = v[ACC_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = v[SAT_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[design/cpga_ram.sv]
// ----------------------------------------------------------------------------
// cpga_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module cpga_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/cpga_diff.sv]
// ----------------------------------------------------------------------------
// cpga_diff
// Three-stage front end: the four basis-by-source products, the cosine and
// sine differences rounded down to Q.32, and the negated sine difference.
// ----------------------------------------------------------------------------
module cpga_diff (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  cpga_pkg::item_ctl_t                  ctl_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     basis_cos_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     basis_sin_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     source_cos_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     source_sin_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     arg_slope_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output cpga_pkg::item_ctl_t                  ctl_o,
  output logic signed [cpga_pkg::DIFF_W-1:0]   cos_diff_o,
  output logic signed [cpga_pkg::NSIN_W-1:0]   nsin_o,
  output logic signed [cpga_pkg::IN_W-1:0]     slope_o
);

  localparam int PROD_W = cpga_pkg::PROD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DIFF_W = cpga_pkg::DIFF_W;
  localparam int NSIN_W = cpga_pkg::NSIN_W;
  localparam int IN_W   = cpga_pkg::IN_W;

  logic s1_en, s2_en, s3_en;
  logic s1_v_q, s2_v_q, s3_v_q;

  cpga_pkg::item_ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic signed [PROD_W-1:0] p_cc_q, p_ss_q, p_sc_q, p_cs_q;
  logic signed [PROD_W-1:0] p_cc_d, p_ss_d, p_sc_d, p_cs_d;
  logic signed [IN_W-1:0]   s1_slope_q, s2_slope_q, s3_slope_q;
  logic signed [SUM_W-1:0]  cos_sum, sin_sum;
  logic signed [DIFF_W-1:0] s2_cos_q, s2_sin_q, s3_cos_q;
  logic signed [NSIN_W-1:0] nsin_q, nsin_d;

  // Each stage advances when empty or when the one after it advances.
  assign s3_en   = !s3_v_q || !stall_i;
  assign s2_en   = !s2_v_q || s3_en;
  assign s1_en   = !s1_v_q || s2_en;
  assign stall_o = !s1_en;

  assign p_cc_d = PROD_W'(basis_cos_i) * PROD_W'(source_cos_i);
  assign p_ss_d = PROD_W'(basis_sin_i) * PROD_W'(source_sin_i);
  assign p_sc_d = PROD_W'(basis_sin_i) * PROD_W'(source_cos_i);
  assign p_cs_d = PROD_W'(basis_cos_i) * PROD_W'(source_sin_i);

  assign cos_sum = SUM_W'(p_cc_q) + SUM_W'(p_ss_q);
  assign sin_sum = SUM_W'(p_sc_q) - SUM_W'(p_cs_q);

  assign nsin_d = -NSIN_W'(s2_sin_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= valid_i;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_ctl_q   <= ctl_i;
      s1_slope_q <= arg_slope_i;
      p_cc_q     <= p_cc_d;
      p_ss_q     <= p_ss_d;
      p_sc_q     <= p_sc_d;
      p_cs_q     <= p_cs_d;
    end
    if (s2_en) begin
      s2_ctl_q   <= s1_ctl_q;
      s2_slope_q <= s1_slope_q;
      s2_cos_q   <= cos_sum[SUM_W-1:cpga_pkg::DIFF_SHIFT];
      s2_sin_q   <= sin_sum[SUM_W-1:cpga_pkg::DIFF_SHIFT];
    end
    if (s3_en) begin
      s3_ctl_q   <= s2_ctl_q;
      s3_slope_q <= s2_slope_q;
      s3_cos_q   <= s2_cos_q;
      nsin_q     <= nsin_d;
    end
  end

  assign valid_o    = s3_v_q;
  assign ctl_o      = s3_ctl_q;
  assign cos_diff_o = s3_cos_q;
  assign nsin_o     = nsin_q;
  assign slope_o    = s3_slope_q;

endmodule

[design/cpga_grad.sv]
// ----------------------------------------------------------------------------
// cpga_grad
// Four-stage gradient path: slope term as two partial products, then
// assembly and clipping; each direction term likewise.
// ----------------------------------------------------------------------------
module cpga_grad (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  cpga_pkg::item_ctl_t                  ctl_i,
  input  logic signed [cpga_pkg::DIFF_W-1:0]   cos_diff_i,
  input  logic signed [cpga_pkg::NSIN_W-1:0]   nsin_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     slope_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     dir_x_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     dir_y_i,
  input  logic signed [cpga_pkg::IN_W-1:0]     dir_z_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output cpga_pkg::item_ctl_t                  ctl_o,
  output logic signed [cpga_pkg::DIFF_W-1:0]   cos_diff_o,
  output logic signed [cpga_pkg::ACC_W-1:0]    grad_x_o,
  output logic signed [cpga_pkg::ACC_W-1:0]    grad_y_o,
  output logic signed [cpga_pkg::ACC_W-1:0]    grad_z_o
);

  localparam int IN_W   = cpga_pkg::IN_W;
  localparam int ACC_W  = cpga_pkg::ACC_W;
  localparam int NSIN_W = cpga_pkg::NSIN_W;
  localparam int DIFF_W = cpga_pkg::DIFF_W;
  localparam int SAT_W  = cpga_pkg::SAT_W;
  localparam int LANES  = cpga_pkg::GRAD_LANES;
  localparam int NL_W   = NSIN_W / 2;
  localparam int NH_W   = NSIN_W - NL_W;
  localparam int PL_W   = NL_W + 1 + IN_W;
  localparam int PH_W   = NH_W + IN_W;
  localparam int SP_W   = NSIN_W + IN_W;
  localparam int GL_W   = ACC_W / 2;
  localparam int GH_W   = ACC_W - GL_W;
  localparam int GPL_W  = GL_W + 1 + IN_W;
  localparam int GPH_W  = GH_W + IN_W;
  localparam int GP_W   = ACC_W + IN_W;

  logic s4_en, s5_en, s6_en, s7_en;
  logic s4_v_q, s5_v_q, s6_v_q, s7_v_q;

  cpga_pkg::item_ctl_t s4_ctl_q, s5_ctl_q, s6_ctl_q, s7_ctl_q;
  cpga_pkg::item_ctl_t s5_ctl_d, s7_ctl_d;
  logic signed [DIFF_W-1:0] s4_cos_q, s5_cos_q, s6_cos_q, s7_cos_q;

  logic signed [PL_W-1:0]   pl_d, pl_q;
  logic signed [PH_W-1:0]   ph_d, ph_q;
  logic signed [SP_W-1:0]   sprod;
  cpga_pkg::sat_res_t       slope_res;
  logic signed [ACC_W-1:0]  st_q;

  logic signed [IN_W-1:0]   dir   [LANES];
  logic signed [GPL_W-1:0]  gpl_d [LANES];
  logic signed [GPL_W-1:0]  gpl_q [LANES];
  logic signed [GPH_W-1:0]  gph_d [LANES];
  logic signed [GPH_W-1:0]  gph_q [LANES];
  logic signed [GP_W-1:0]   gprod [LANES];
  cpga_pkg::sat_res_t       gres  [LANES];
  logic signed [ACC_W-1:0]  grad_q [LANES];
  logic                     grad_sat;

  assign s7_en   = !s7_v_q || !stall_i;
  assign s6_en   = !s6_v_q || s7_en;
  assign s5_en   = !s5_v_q || s6_en;
  assign s4_en   = !s4_v_q || s5_en;
  assign stall_o = !s4_en;

  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  // Slope term: split -sinDiff into unsigned low and signed high halves.
  assign pl_d = PL_W'($signed({1'b0, nsin_i[NL_W-1:0]})) * PL_W'(slope_i);
  assign ph_d = PH_W'($signed(nsin_i[NSIN_W-1:NL_W])) * PH_W'(slope_i);

  assign sprod     = (SP_W'(ph_q) <<< NL_W) + SP_W'(pl_q);
  assign slope_res = cpga_pkg::sat_acc(sprod[SP_W-1:cpga_pkg::SLOPE_SHIFT]);

  always_comb begin
    grad_sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      gpl_d[l] = GPL_W'($signed({1'b0, st_q[GL_W-1:0]})) * GPL_W'(dir[l]);
      gph_d[l] = GPH_W'($signed(st_q[ACC_W-1:GL_W])) * GPH_W'(dir[l]);
      gprod[l] = (GP_W'(gph_q[l]) <<< GL_W) + GP_W'(gpl_q[l]);
      gres[l]  = cpga_pkg::sat_acc(SAT_W'($signed(gprod[l][GP_W-1:cpga_pkg::DIR_SHIFT])));
      grad_sat = grad_sat | gres[l].sat;
    end
  end

  // Fold the slope and direction clip flags into the control word.
  always_comb begin
    s5_ctl_d     = s4_ctl_q;
    s5_ctl_d.sat = s4_ctl_q.sat | slope_res.sat;
    s7_ctl_d     = s6_ctl_q;
    s7_ctl_d.sat = s6_ctl_q.sat | grad_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else begin
      if (s4_en) s4_v_q <= valid_i;
      if (s5_en) s5_v_q <= s4_v_q;
      if (s6_en) s6_v_q <= s5_v_q;
      if (s7_en) s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_ctl_q <= ctl_i;
      s4_cos_q <= cos_diff_i;
      pl_q     <= pl_d;
      ph_q     <= ph_d;
    end
    if (s5_en) begin
      s5_ctl_q <= s5_ctl_d;
      s5_cos_q <= s4_cos_q;
      st_q     <= slope_res.val;
    end
    if (s6_en) begin
      s6_ctl_q <= s5_ctl_q;
      s6_cos_q <= s5_cos_q;
      for (int l = 0; l < LANES; l++) begin
        gpl_q[l] <= gpl_d[l];
        gph_q[l] <= gph_d[l];
      end
    end
    if (s7_en) begin
      s7_ctl_q <= s7_ctl_d;
      s7_cos_q <= s6_cos_q;
      for (int l = 0; l < LANES; l++) begin
        grad_q[l] <= gres[l].val;
      end
    end
  end

  assign valid_o    = s7_v_q;
  assign ctl_o      = s7_ctl_q;
  assign cos_diff_o = s7_cos_q;
  assign grad_x_o   = grad_q[0];
  assign grad_y_o   = grad_q[1];
  assign grad_z_o   = grad_q[2];

endmodule

[design/cpga_acc.sv]
// ----------------------------------------------------------------------------
// cpga_acc
// Accumulator store and update: read stage into the RAM, then add, clip,
// write back and hold the result in the output register.
// ----------------------------------------------------------------------------
module cpga_acc #(
  parameter int ELEMENTS = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  cpga_pkg::item_ctl_t                  ctl_i,
  input  logic signed [cpga_pkg::DIFF_W-1:0]   cos_diff_i,
  input  logic signed [cpga_pkg::ACC_W-1:0]    grad_x_i,
  input  logic signed [cpga_pkg::ACC_W-1:0]    grad_y_i,
  input  logic signed [cpga_pkg::ACC_W-1:0]    grad_z_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic [cpga_pkg::IDX_W-1:0]           index_o,
  output logic signed [cpga_pkg::ACC_W-1:0]    potential_o,
  output logic signed [cpga_pkg::ACC_W-1:0]    grad_x_o,
  output logic signed [cpga_pkg::ACC_W-1:0]    grad_y_o,
  output logic signed [cpga_pkg::ACC_W-1:0]    grad_z_o,
  output logic                                 sat_o
);

  localparam int IDX_W   = cpga_pkg::IDX_W;
  localparam int ACC_W   = cpga_pkg::ACC_W;
  localparam int DIFF_W  = cpga_pkg::DIFF_W;
  localparam int SAT_W   = cpga_pkg::SAT_W;
  localparam int LANES   = cpga_pkg::ACC_LANES;
  localparam int SUM_W   = DIFF_W + 1;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int DEPTH   = (ELEMENTS < IDX_SPAN) ? ELEMENTS : IDX_SPAN;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = ($clog2(ELEMENTS + 1) > IDX_W) ? $clog2(ELEMENTS + 1) : IDX_W;
  localparam int RAM_W   = LANES * ACC_W;

  logic r_en, o_en;
  logic r_v_q, o_v_q;

  cpga_pkg::item_ctl_t     r_ctl_q;
  logic signed [SUM_W-1:0] term  [LANES];
  logic signed [SUM_W-1:0] term_q [LANES];
  logic signed [ACC_W-1:0] old   [LANES];
  logic signed [SUM_W-1:0] acc_sum [LANES];
  cpga_pkg::sat_res_t      ares  [LANES];
  logic signed [ACC_W-1:0] o_sum_q [LANES];
  logic [IDX_W-1:0]        o_idx_q;
  logic                    o_sat_q;
  logic                    acc_sat;

  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [RAM_W-1:0]  rd_data, wr_data;
  logic              we;
  logic              in_range, use_old;
  logic [DEPTH-1:0]  vld_q;
  logic              vld_rd_q, byp_q;

  assign o_en    = !o_v_q || !stall_i;
  assign r_en    = !r_v_q || o_en;
  assign stall_o = !r_en;

  assign term[0] = SUM_W'(cos_diff_i);
  assign term[1] = SUM_W'(grad_x_i);
  assign term[2] = SUM_W'(grad_y_i);
  assign term[3] = SUM_W'(grad_z_i);

  // Read the entry of the request entering the read stage, else re-read own.
  assign rd_addr  = r_en ? ctl_i.idx[ADDR_W-1:0] : r_ctl_q.idx[ADDR_W-1:0];
  assign wr_addr  = r_ctl_q.idx[ADDR_W-1:0];
  assign in_range = CMP_W'(r_ctl_q.idx) < CMP_W'(ELEMENTS);
  assign use_old  = in_range && !r_ctl_q.first;
  assign we       = o_en && r_v_q && in_range;

  always_comb begin
    acc_sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      // Forward the value written on the last edge; unwritten entries are zero.
      if (!use_old) begin
        old[l] = '0;
      end else if (byp_q) begin
        old[l] = o_sum_q[l];
      end else if (vld_rd_q) begin
        old[l] = rd_data[l*ACC_W +: ACC_W];
      end else begin
        old[l] = '0;
      end
      acc_sum[l] = SUM_W'(old[l]) + term_q[l];
      ares[l]    = cpga_pkg::sat_acc(SAT_W'(acc_sum[l]));
      acc_sat    = acc_sat | ares[l].sat;
      wr_data[l*ACC_W +: ACC_W] = ares[l].val;
    end
  end

  cpga_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q    <= 1'b0;
      o_v_q    <= 1'b0;
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (r_en) r_v_q <= valid_i;
      if (o_en) o_v_q <= r_v_q;
      if (we) vld_q[wr_addr] <= 1'b1;
      vld_rd_q <= vld_q[rd_addr];
      byp_q    <= we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_en) begin
      r_ctl_q <= ctl_i;
      for (int l = 0; l < LANES; l++) begin
        term_q[l] <= term[l];
      end
    end
    if (o_en) begin
      o_idx_q <= r_ctl_q.idx;
      o_sat_q <= r_ctl_q.sat | acc_sat;
      for (int l = 0; l < LANES; l++) begin
        o_sum_q[l] <= ares[l].val;
      end
    end
  end

  assign valid_o     = o_v_q;
  assign index_o     = o_idx_q;
  assign potential_o = o_sum_q[0];
  assign grad_x_o    = o_sum_q[1];
  assign grad_y_o    = o_sum_q[2];
  assign grad_z_o    = o_sum_q[3];
  assign sat_o       = o_sat_q;

endmodule

[design/cross_potential_gradient_accumulate_unit.sv]
// ----------------------------------------------------------------------------
// cross_potential_gradient_accumulate_unit
// Per-element cross-potential and gradient accumulation with saturation.
// ----------------------------------------------------------------------------
// Each request carries one basis element (cos/sin basis values in Q1.30,
// summed source potentials and argument slope in Q15.16, element index and
// a first-pass flag). The unit forms cosDiff = c*C + s*S and
// sinDiff = s*C - c*S (rounded down to Q.32), adds cosDiff to the element's
// potential accumulator and -sinDiff*slope*dir to its x/y/z gradient
// accumulators, dir being the sphere direction written over the config
// port (index 0..2 = x, y, z; index 3 is ignored). A first-pass request
// overwrites the four accumulators instead of adding. Accumulators are
// 48-bit Q15.32 and clip; so do the intermediate slope and direction terms,
// and any clip sets the saturated flag of the result. Indexes at or above
// ELEMENTS update nothing and report the terms as if the old values were
// zero. One result comes out per request, in order.
// Throughput is one request per clock while the output is not stalled. The
// pipeline runs from acceptance to the result on the output through three
// product and difference stages, four slope and direction multiply stages
// (each wide product split into two partials, then assembled and clipped),
// an accumulator RAM read stage and an add, clip and write-back stage.
// Back-to-back requests to the same element are exact: the value written
// on the previous edge is forwarded around the RAM. Accumulators come out
// of reset as zero through per-entry valid bits, so no clearing pass is
// needed. Each stage advances whenever it is empty, so bubbles close up
// while the output is stalled.
// ----------------------------------------------------------------------------
module cross_potential_gradient_accumulate_unit #(
  parameter int ELEMENTS = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [cpga_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cpga_pkg::IN_W-1:0]             cfg_wdata_i,

  // Request channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cpga_pkg::IDX_W-1:0]            element_index_i,
  input  logic signed [cpga_pkg::IN_W-1:0]      basis_cos_i,
  input  logic signed [cpga_pkg::IN_W-1:0]      basis_sin_i,
  input  logic signed [cpga_pkg::IN_W-1:0]      source_cos_i,
  input  logic signed [cpga_pkg::IN_W-1:0]      source_sin_i,
  input  logic signed [cpga_pkg::IN_W-1:0]      arg_slope_i,
  input  logic                                  first_pass_i,

  // Result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [cpga_pkg::IDX_W-1:0]            result_index_o,
  output logic signed [cpga_pkg::ACC_W-1:0]     potential_sum_o,
  output logic signed [cpga_pkg::ACC_W-1:0]     gradient_x_sum_o,
  output logic signed [cpga_pkg::ACC_W-1:0]     gradient_y_sum_o,
  output logic signed [cpga_pkg::ACC_W-1:0]     gradient_z_sum_o,
  output logic                                  saturated_o
);

  localparam int IN_W = cpga_pkg::IN_W;

  // Sphere direction registers, Q1.30.
  logic signed [IN_W-1:0] dir_x_q, dir_y_q, dir_z_q;

  cpga_pkg::item_ctl_t in_ctl;

  // Front end to gradient path
  logic                                  d_valid, d_stall;
  cpga_pkg::item_ctl_t                   d_ctl;
  logic signed [cpga_pkg::DIFF_W-1:0]    d_cos;
  logic signed [cpga_pkg::NSIN_W-1:0]    d_nsin;
  logic signed [IN_W-1:0]                d_slope;

  // Gradient path to accumulator
  logic                                  g_valid, g_stall;
  cpga_pkg::item_ctl_t                   g_ctl;
  logic signed [cpga_pkg::DIFF_W-1:0]    g_cos;
  logic signed [cpga_pkg::ACC_W-1:0]     g_x, g_y, g_z;

  // Decode config writes; an unused index drops the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q <= '0;
      dir_y_q <= '0;
      dir_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cpga_pkg::cfg_reg_e'(cfg_idx_i))
        cpga_pkg::CFG_DIR_X: dir_x_q <= cfg_wdata_i;
        cpga_pkg::CFG_DIR_Y: dir_y_q <= cfg_wdata_i;
        cpga_pkg::CFG_DIR_Z: dir_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clip flag starts clear and collects along the pipe.
  assign in_ctl.first = first_pass_i;
  assign in_ctl.idx   = element_index_i;
  assign in_ctl.sat   = 1'b0;

  cpga_diff u_diff (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .stall_o      (in_stall_o),
    .ctl_i        (in_ctl),
    .basis_cos_i  (basis_cos_i),
    .basis_sin_i  (basis_sin_i),
    .source_cos_i (source_cos_i),
    .source_sin_i (source_sin_i),
    .arg_slope_i  (arg_slope_i),
    .valid_o      (d_valid),
    .stall_i      (d_stall),
    .ctl_o        (d_ctl),
    .cos_diff_o   (d_cos),
    .nsin_o       (d_nsin),
    .slope_o      (d_slope)
  );

  cpga_grad u_grad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (d_valid),
    .stall_o    (d_stall),
    .ctl_i      (d_ctl),
    .cos_diff_i (d_cos),
    .nsin_i     (d_nsin),
    .slope_i    (d_slope),
    .dir_x_i    (dir_x_q),
    .dir_y_i    (dir_y_q),
    .dir_z_i    (dir_z_q),
    .valid_o    (g_valid),
    .stall_i    (g_stall),
    .ctl_o      (g_ctl),
    .cos_diff_o (g_cos),
    .grad_x_o   (g_x),
    .grad_y_o   (g_y),
    .grad_z_o   (g_z)
  );

  cpga_acc #(
    .ELEMENTS (ELEMENTS)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (g_valid),
    .stall_o     (g_stall),
    .ctl_i       (g_ctl),
    .cos_diff_i  (g_cos),
    .grad_x_i    (g_x),
    .grad_y_i    (g_y),
    .grad_z_i    (g_z),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .index_o     (result_index_o),
    .potential_o (potential_sum_o),
    .grad_x_o    (gradient_x_sum_o),
    .grad_y_o    (gradient_y_sum_o),
    .grad_z_o    (gradient_z_sum_o),
    .sat_o       (saturated_o)
  );

endmodule
